/* sv/scs_pkg.sv */
`timescale 1ns / 1ps

package scs_pkg;

  // Sync marker and command bit fields.
  localparam logic [7:0]  SYNC_BYTE = 8'hFF;
  localparam int unsigned RESET_BIT = 7;
  localparam logic [15:0] PAN_RESET = 16'd65281;

  // Reset values of the servo compare registers.
  localparam logic [15:0] SERVO_TILT0_RESET  = 16'd1600;
  localparam logic [15:0] SERVO_TILT45_RESET = 16'd2220;
  localparam logic [15:0] SERVO_TILT90_RESET = 16'd2840;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT0  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT45 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT90 = 2'd2;

  // Tilt positions as carried in the tilt selector bits.
  typedef enum logic [1:0] {
    TILT_0  = 2'd0,
    TILT_45 = 2'd1,
    TILT_90 = 2'd2
  } tilt_e;

  // Reply flag bit positions.
  localparam int unsigned FLAG_LOW_ESC  = 0;
  localparam int unsigned FLAG_HIGH_ESC = 1;
  localparam int unsigned FLAG_TILT45   = 2;
  localparam int unsigned FLAG_TILT90   = 3;

  // One reply to a command.
  typedef struct packed {
    logic [7:0]  reply_high;
    logic [7:0]  reply_low;
    logic [3:0]  reply_flags;
    logic [7:0]  coil_pattern;
    logic [15:0] servo_compare;
    logic        did_reset;
    logic [15:0] reverse_steps;
  } reply_t;

  // Coil port value for each of the eight half-step phases.
  function automatic logic [7:0] coil_of_phase(input logic [2:0] phase);
    logic [7:0] pattern;
    unique case (phase)
      3'd0: pattern = 8'h08;
      3'd1: pattern = 8'h48;
      3'd2: pattern = 8'h40;
      3'd3: pattern = 8'h41;
      3'd4: pattern = 8'h01;
      3'd5: pattern = 8'h81;
      3'd6: pattern = 8'h80;
      3'd7: pattern = 8'h88;
      default: pattern = 8'h08;
    endcase
    return pattern;
  endfunction

endpackage

/* sv/scs_rx_if.sv */
`timescale 1ns / 1ps

// Received byte channel.
interface scs_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/scs_reply_if.sv */
`timescale 1ns / 1ps

// Command reply channel.
interface scs_reply_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_high;
  logic [7:0]  reply_low;
  logic [3:0]  reply_flags;
  logic [7:0]  coil_pattern;
  logic [15:0] servo_compare;
  logic        did_reset;
  logic [15:0] reverse_steps;

  modport source (
    output valid, output reply_high, output reply_low, output reply_flags,
    output coil_pattern, output servo_compare, output did_reset, output reverse_steps,
    input ready
  );
  modport sink (
    input valid, input reply_high, input reply_low, input reply_flags,
    input coil_pattern, input servo_compare, input did_reset, input reverse_steps,
    output ready
  );
endinterface

/* sv/scanner_command_stepper_servo_top.sv */
`timescale 1ns / 1ps

// Pan/tilt scanner command decoder. Received bytes enter an input register;
// a byte of 255 arms sync and the next other byte is a command that yields
// one reply, while every other byte is dropped without a reply. A command
// steps the half-step coil pattern forward and counts pan, or with bit 7 set
// rewinds the phase by the pan count in one go and reports that count. The
// block takes one byte per clock cycle and each byte is handled in a single
// pass from the input register to the reply register, where the reply to a
// command is registered. The only limit on rate is the reply register: a byte
// waits in the input register while an undelivered reply still sits in the
// reply register. The three servo compare registers may be written only
// while no byte is in flight.
module scanner_command_stepper_servo_top
  import scs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  scs_rx_if.sink               rx_i,
  scs_reply_if.source          reply_o
);

  // Input stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Block state.
  logic        sync_q, sync_d;
  logic [15:0] pan_q, pan_d;
  tilt_e       tilt_req_q, tilt_req_d;
  logic [2:0]  phase_q, phase_d;
  logic        first_q, first_d;

  // Servo compare registers.
  logic [15:0] servo_tilt0_q, servo_tilt45_q, servo_tilt90_q;

  // Reply stage.
  logic   out_valid_q;
  reply_t out_q, out_d;

  logic  out_free;
  logic  advance;
  logic  is_cmd;
  logic  is_reset;
  tilt_e tilt_now;

  assign out_free   = !out_valid_q || reply_o.ready;
  assign advance    = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Command decode, state update and reply formation.
  always_comb begin
    logic [7:0] hi;
    logic [7:0] lo;
    sync_d     = sync_q;
    pan_d      = pan_q;
    tilt_req_d = tilt_req_q;
    phase_d    = phase_q;
    first_d    = first_q;
    out_d      = '0;
    tilt_now   = tilt_req_q;
    is_cmd     = 1'b0;
    is_reset   = in_byte_q[RESET_BIT];

    if (in_byte_q == SYNC_BYTE) begin
      sync_d = 1'b1;
    end else if (sync_q) begin
      sync_d = 1'b0;
      is_cmd = 1'b1;
    end

    // Tilt selector: codes above 90 degrees keep the earlier request.
    unique case (in_byte_q[3:0])
      4'd0:    tilt_req_d = TILT_0;
      4'd1:    tilt_req_d = TILT_45;
      4'd2:    tilt_req_d = TILT_90;
      default: tilt_req_d = tilt_req_q;
    endcase
    if (!is_cmd) begin
      tilt_req_d = tilt_req_q;
    end
    tilt_now = tilt_req_d;

    if (is_cmd) begin
      if (is_reset) begin
        phase_d  = phase_q - pan_q[2:0];
        pan_d    = '0;
        tilt_now = TILT_0;
        first_d  = 1'b1;
        out_d.reverse_steps = pan_q;
      end else begin
        phase_d = phase_q + 3'd1;
        first_d = 1'b0;
        pan_d   = first_q ? 16'd0 : pan_q + 16'd1;
      end
    end

    // Reply with the 255 escape on each pan byte.
    hi = pan_d[15:8];
    lo = pan_d[7:0];
    out_d.reply_flags[FLAG_HIGH_ESC] = (hi == 8'hFF);
    out_d.reply_flags[FLAG_LOW_ESC]  = (lo == 8'hFF);
    out_d.reply_high = (hi == 8'hFF) ? 8'h00 : hi;
    out_d.reply_low  = (lo == 8'hFF) ? 8'h00 : lo;
    out_d.reply_flags[FLAG_TILT45] = (tilt_now == TILT_45);
    out_d.reply_flags[FLAG_TILT90] = (tilt_now == TILT_90);
    out_d.coil_pattern = coil_of_phase(phase_d);
    out_d.did_reset    = is_reset;
    unique case (tilt_now)
      TILT_45: out_d.servo_compare = servo_tilt45_q;
      TILT_90: out_d.servo_compare = servo_tilt90_q;
      default: out_d.servo_compare = servo_tilt0_q;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q     <= 1'b0;
      pan_q      <= PAN_RESET;
      tilt_req_q <= TILT_0;
      phase_q    <= 3'd0;
      first_q    <= 1'b1;
    end else if (advance) begin
      sync_q     <= sync_d;
      pan_q      <= pan_d;
      tilt_req_q <= tilt_req_d;
      phase_q    <= phase_d;
      first_q    <= first_d;
    end
  end

  // Servo compare register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_tilt0_q  <= SERVO_TILT0_RESET;
      servo_tilt45_q <= SERVO_TILT45_RESET;
      servo_tilt90_q <= SERVO_TILT90_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TILT0:  servo_tilt0_q  <= cfg_data_i;
        CFG_TILT45: servo_tilt45_q <= cfg_data_i;
        CFG_TILT90: servo_tilt90_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Reply register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && is_cmd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_cmd) begin
      out_q <= out_d;
    end
  end

  assign reply_o.valid         = out_valid_q;
  assign reply_o.reply_high    = out_q.reply_high;
  assign reply_o.reply_low     = out_q.reply_low;
  assign reply_o.reply_flags   = out_q.reply_flags;
  assign reply_o.coil_pattern  = out_q.coil_pattern;
  assign reply_o.servo_compare = out_q.servo_compare;
  assign reply_o.did_reset     = out_q.did_reset;
  assign reply_o.reverse_steps = out_q.reverse_steps;

  // A reset reply reports zero pan and zero tilt.
  a_reset_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.did_reset |->
      out_q.reply_high == 8'h00 && out_q.reply_low == 8'h00 &&
      out_q.reply_flags == 4'h0)
    else $error("reset reply carries nonzero pan or tilt");

  // Only one tilt flag can be set.
  a_tilt_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.reply_flags[FLAG_TILT45] && out_q.reply_flags[FLAG_TILT90]))
    else $error("both tilt flags set");

  // A processed reset command rearms the first step and clears pan.
  a_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_cmd && is_reset |=> first_q && pan_q == 16'd0)
    else $error("reset command did not clear pan state");

  // A processed sync byte leaves sync armed.
  a_sync_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_byte_q == SYNC_BYTE |=> sync_q)
    else $error("sync byte did not arm sync");

  // A reply stalled by the sink keeps the byte behind it waiting.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !reply_o.ready |-> !advance)
    else $error("byte processed while reply stalled");

endmodule

/* test/scs_reply_checker.sv */
`timescale 1ns / 1ps

// Watches the byte and reply channels of the scanner command decoder. It keeps
// its own copy of the decoder state, works out the reply for every accepted
// command request and compares each delivered reply, field by field, with the
// oldest reply still owed.
module scs_reply_checker
  import scs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  scs_rx_if                    rx_mon,
  scs_reply_if                 reply_mon,
  output int unsigned          mismatches_o,
  output int unsigned          replies_pending_o
);

  // Coil port values of half-step phases 0 to 7, phase 0 in the low byte.
  localparam logic [63:0] COIL_BY_PHASE = 64'h8880_8101_4140_4808;
  localparam int unsigned MAX_PRINTED = 20;

  // Mirror of the decoder state and of the servo compare registers.
  logic        sync_armed;
  logic [15:0] pan;
  tilt_e       tilt_req;
  logic [2:0]  phase;
  logic        fresh_start;
  logic [15:0] servo_cmp [3];

  reply_t      replies_owed [$];
  int unsigned mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] reply mismatch: %s", $realtime, what);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, should be 0x%0h", name, got, want));
    end
  endtask

  // Advance the mirror by one received byte and queue the reply it causes.
  task automatic decode_byte(input logic [7:0] rx_byte);
    reply_t      owed;
    logic [3:0]  sel;
    tilt_e       tilt_now;
    logic [15:0] rev;
    if (rx_byte == SYNC_BYTE) begin
      sync_armed = 1'b1;
    end else if (sync_armed) begin
      sync_armed = 1'b0;
      sel = rx_byte[3:0];
      // Unused selector values keep the previous request.
      if (sel <= 4'(TILT_90)) begin
        tilt_req = tilt_e'(sel[1:0]);
      end
      tilt_now = tilt_req;
      rev = '0;
      if (rx_byte[RESET_BIT]) begin
        // A rewind steps back once per pan count, so only count mod 8 matters.
        rev = pan;
        phase = phase - rev[2:0];
        pan = '0;
        tilt_now = TILT_0;
        fresh_start = 1'b1;
      end else begin
        phase = phase + 3'd1;
        if (fresh_start) begin
          fresh_start = 1'b0;
          pan = '0;
        end else begin
          pan = pan + 16'd1;
        end
      end
      owed = '0;
      owed.reply_high = (pan[15:8] == SYNC_BYTE) ? 8'h00 : pan[15:8];
      owed.reply_low  = (pan[7:0] == SYNC_BYTE) ? 8'h00 : pan[7:0];
      owed.reply_flags[FLAG_HIGH_ESC] = (pan[15:8] == SYNC_BYTE);
      owed.reply_flags[FLAG_LOW_ESC]  = (pan[7:0] == SYNC_BYTE);
      owed.reply_flags[FLAG_TILT45]   = (tilt_now == TILT_45);
      owed.reply_flags[FLAG_TILT90]   = (tilt_now == TILT_90);
      owed.coil_pattern  = COIL_BY_PHASE[{phase, 3'b000} +: 8];
      owed.servo_compare = servo_cmp[int'(tilt_now)];
      owed.did_reset     = rx_byte[RESET_BIT];
      owed.reverse_steps = rev;
      replies_owed.push_back(owed);
    end
  endtask

  task automatic compare_reply();
    reply_t want;
    if (replies_owed.size() == 0) begin
      report_mismatch("reply delivered while no command was outstanding");
    end else begin
      want = replies_owed.pop_front();
      check_field("reply_high", 16'(reply_mon.reply_high), 16'(want.reply_high));
      check_field("reply_low", 16'(reply_mon.reply_low), 16'(want.reply_low));
      check_field("reply_flags", 16'(reply_mon.reply_flags), 16'(want.reply_flags));
      check_field("coil_pattern", 16'(reply_mon.coil_pattern), 16'(want.coil_pattern));
      check_field("servo_compare", reply_mon.servo_compare, want.servo_compare);
      check_field("did_reset", 16'(reply_mon.did_reset), 16'(want.did_reset));
      check_field("reverse_steps", reply_mon.reverse_steps, want.reverse_steps);
    end
  endtask

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_armed   = 1'b0;
      pan          = PAN_RESET;
      tilt_req     = TILT_0;
      phase        = 3'd0;
      fresh_start  = 1'b1;
      servo_cmp[0] = SERVO_TILT0_RESET;
      servo_cmp[1] = SERVO_TILT45_RESET;
      servo_cmp[2] = SERVO_TILT90_RESET;
      replies_owed.delete();
      replies_pending_o <= 0;
    end else begin
      if (reply_mon.valid && reply_mon.ready) begin
        compare_reply();
      end
      if (rx_mon.valid && rx_mon.ready) begin
        decode_byte(rx_mon.rx_byte);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TILT0:  servo_cmp[0] = cfg_data_i;
          CFG_TILT45: servo_cmp[1] = cfg_data_i;
          CFG_TILT90: servo_cmp[2] = cfg_data_i;
          default: ;
        endcase
      end
      replies_pending_o <= replies_owed.size();
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

// Drives the scanner command decoder with byte requests and random reply
// back-pressure, programs the servo registers between phases and reports the
// verdict from the checker's mismatch count.
module tb;
  import scs_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned SWEEP_STEPS    = 260;
  localparam int unsigned PHASE_REQUESTS = 25;
  localparam int unsigned RANDOM_PHASES  = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Selector values outside the tilt codes, which keep the previous request.
  localparam logic [3:0] TILT_KEEP_LOW  = 4'd3;
  localparam logic [3:0] TILT_KEEP_MID  = 4'd12;
  localparam logic [3:0] TILT_KEEP_HIGH = 4'd15;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]          cfg_data;
  int unsigned          mismatches;
  int unsigned          replies_pending;

  bit                   src_idle;
  bit                   sink_stalls;
  int unsigned          stall_left = 0;

  scs_rx_if    rx ();
  scs_reply_if reply ();

  scanner_command_stepper_servo_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx),
    .reply_o    (reply)
  );

  scs_reply_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .rx_mon            (rx),
    .reply_mon         (reply),
    .mismatches_o      (mismatches),
    .replies_pending_o (replies_pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly short delays with an occasional long one.
  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 93) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(12, 40);
  endfunction

  function automatic int unsigned pick_gap();
    if (!src_idle || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return pick_delay();
  endfunction

  function automatic logic [7:0] command_byte(input bit rewind, input logic [2:0] spare,
                                              input logic [3:0] tilt_sel);
    logic [7:0] cmd;
    cmd = {1'b0, spare, tilt_sel};
    cmd[RESET_BIT] = rewind;
    return cmd;
  endfunction

  // Random command: tilt codes favored, rewinds kept rare so pan can grow.
  function automatic logic [7:0] random_command();
    logic [7:0] cmd;
    cmd = 8'($urandom_range(0, 254));
    if (cmd[RESET_BIT] && $urandom_range(0, 4) != 0) begin
      cmd[RESET_BIT] = 1'b0;
    end
    if ($urandom_range(0, 1) != 0) begin
      cmd[3:0] = 4'($urandom_range(int'(TILT_0), int'(TILT_90)));
    end
    return cmd;
  endfunction

  // Reply back-pressure: stalls of random length when enabled.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      reply.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      reply.ready <= 1'b1;
      if (sink_stalls && $urandom_range(0, 99) < 20) begin
        stall_left <= pick_delay();
      end
    end
  end

  // Offer one byte request and hold it until accepted; called just after an edge.
  task automatic send_byte(input logic [7:0] rx_byte, input int unsigned gap);
    if (gap != 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= rx_byte;
    do @(posedge clk_i); while (!rx.ready);
  endtask

  task automatic send_command(input logic [7:0] cmd);
    send_byte(SYNC_BYTE, pick_gap());
    send_byte(cmd, pick_gap());
  endtask

  // Let every owed reply arrive, then give a dropped byte time to clear.
  task automatic drain_replies();
    rx.valid <= 1'b0;
    do @(posedge clk_i); while (replies_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three servo registers and one index past the last register.
  task automatic program_servo(input logic [15:0] tilt0, input logic [15:0] tilt45,
                               input logic [15:0] tilt90);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TILT0;
    cfg_data <= tilt0;
    @(posedge clk_i);
    cfg_idx  <= CFG_TILT45;
    cfg_data <= tilt45;
    @(posedge clk_i);
    cfg_idx  <= CFG_TILT90;
    cfg_data <= tilt90;
    @(posedge clk_i);
    cfg_idx  <= CFG_UNUSED;
    cfg_data <= 16'($urandom);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Run limit.
  initial begin
    for (int unsigned cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
      @(posedge clk_i);
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned requests;
    int unsigned r;
    logic [7:0]  noise;
    bit          phase_src_idle;
    bit          phase_sink_stalls;

    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_TILT0;
    cfg_data    = '0;
    rx.valid    = 1'b0;
    rx.rx_byte  = '0;
    reply.ready = 1'b0;
    src_idle    = 1'b1;
    sink_stalls = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the register reset values.
    // A rewind before any step reports the reset pan count.
    send_command(command_byte(1'b1, 3'd0, 4'(TILT_0)));
    // Bytes without sync are dropped.
    send_byte(8'h00, pick_gap());
    send_byte(8'h7F, pick_gap());
    // Repeated sync stays armed; first step after a rewind starts pan at zero.
    send_byte(SYNC_BYTE, pick_gap());
    send_command(command_byte(1'b0, 3'd0, 4'(TILT_45)));
    send_command(command_byte(1'b0, 3'd0, 4'(TILT_90)));
    // Unused selectors and the spare bits leave the tilt as it was.
    send_command(command_byte(1'b0, 3'd0, TILT_KEEP_HIGH));
    send_command(command_byte(1'b0, 3'd7, TILT_KEEP_LOW));
    // A rewind takes the tilt request but parks the servo at zero degrees.
    send_command(command_byte(1'b1, 3'd0, 4'(TILT_90)));
    send_command(command_byte(1'b0, 3'd0, TILT_KEEP_MID));
    // Largest command byte: a rewind with an unused selector.
    send_command(command_byte(1'b1, 3'd7, 4'hE));
    send_command(command_byte(1'b0, 3'd0, 4'(TILT_0)));
    send_byte(8'hFE, pick_gap());
    drain_replies();

    // Pan sweep past the escaped low byte, with no idling.
    program_servo(16'h0000, 16'hFFFF, 16'h8001);
    src_idle    = 1'b0;
    sink_stalls = 1'b0;
    for (int unsigned n = 0; n < SWEEP_STEPS; n++) begin
      send_command(command_byte(1'b0, 3'($urandom), 4'($urandom)));
    end
    send_command(command_byte(1'b1, 3'($urandom), 4'(TILT_45)));
    drain_replies();

    // Random phases, each under its own servo settings and idling mix.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        program_servo(16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else if (p == 2) begin
        program_servo(SERVO_TILT0_RESET, 16'h0000, 16'hFFFF);
      end else begin
        program_servo(16'($urandom), 16'($urandom), 16'($urandom));
      end
      phase_src_idle    = (p != 2);
      phase_sink_stalls = (p != 1);
      requests = 0;
      while (requests < PHASE_REQUESTS) begin
        // Stretches without idling fall inside every phase.
        if (requests % 10 == 0) begin
          src_idle    = phase_src_idle && ($urandom_range(0, 3) != 0);
          sink_stalls = phase_sink_stalls && ($urandom_range(0, 3) != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
          send_command(random_command());
          requests += 2;
        end else if (r < 85) begin
          repeat ($urandom_range(1, 3)) begin
            send_byte(SYNC_BYTE, pick_gap());
            requests++;
          end
          send_command(random_command());
          requests += 2;
        end else begin
          noise = 8'($urandom_range(0, 255));
          send_byte(noise, pick_gap());
          if (noise == SYNC_BYTE) begin
            requests++;
          end
        end
      end
      drain_replies();
    end

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
